// ===== sv/key_debounce_repeat_long_press_macros.svh =====
// Assertion helpers shared by the key scanner block.
// Both sample on clk and stay quiet while rst_n is low.
`ifndef KEY_DEBOUNCE_REPEAT_LONG_PRESS_MACROS_SVH
`define KEY_DEBOUNCE_REPEAT_LONG_PRESS_MACROS_SVH

// Check the consequent in the same cycle as the antecedent.
`define KDRLP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kdrlp check failed");

// Check the consequent in the cycle after the antecedent.
`define KDRLP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kdrlp check failed");

`endif

// ===== sv/kdrlp_pkg.sv =====
`timescale 1ns / 1ps

package kdrlp_pkg;

    localparam int NUM_KEYS    = 4;
    localparam int COUNT_WIDTH = 16;
    localparam int CFG_WIDTH   = 16;
    localparam int LEVEL_BITS  = 4;
    localparam int KEY_WIDTH   = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CMP_WIDTH   = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [CFG_WIDTH-1:0]   cfg_word_t;
    typedef logic [CMP_WIDTH-1:0]   cmp_t;
    typedef logic [KEY_WIDTH-1:0]   key_num_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE  = 2'd0,
        REG_RPT_START = 2'd1,
        REG_RPT_INTV  = 2'd2,
        REG_LONG      = 2'd3
    } cfg_reg_t;

    localparam cfg_word_t DEBOUNCE_RST  = 16'd2;
    localparam cfg_word_t RPT_START_RST = 16'd100;
    localparam cfg_word_t RPT_INTV_RST  = 16'd20;
    localparam cfg_word_t LONG_RST      = 16'd150;

    // Thresholds shared by every lane
    typedef struct packed {
        cfg_word_t debounce;
        cfg_word_t rpt_start;
        cfg_word_t rpt_intv;
        cfg_word_t long_press;
    } cfg_t;

    // What one lane found on the current tick
    typedef struct packed {
        logic hit;
        logic long_rel;
    } lane_evt_t;

endpackage

// ===== sv/kdrlp_lane.sv =====
`timescale 1ns / 1ps

module kdrlp_lane
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                released,
    input  kdrlp_pkg::cfg_t     cfg,
    output kdrlp_pkg::lane_evt_t evt
);

    kdrlp_pkg::count_t press_reg;
    kdrlp_pkg::count_t press_next;
    kdrlp_pkg::count_t repeat_reg;
    kdrlp_pkg::count_t repeat_next;
    logic              locked_reg;
    logic              locked_next;
    logic              long_reg;
    logic              long_next;
    kdrlp_pkg::count_t press_inc;
    kdrlp_pkg::count_t repeat_inc;

    // Saturating increments
    assign press_inc  = (press_reg == '1) ? press_reg : press_reg + 1'b1;
    assign repeat_inc = (repeat_reg == '1) ? repeat_reg : repeat_reg + 1'b1;

    // Work out this key's next state and event
    always_comb
    begin
        press_next   = press_reg;
        repeat_next  = repeat_reg;
        locked_next  = locked_reg;
        long_next    = long_reg;
        evt.hit      = 1'b0;
        evt.long_rel = 1'b0;
        if (released)
        begin
            locked_next = 1'b0;
            press_next  = '0;
            if (long_reg)
            begin
                long_next    = 1'b0;
                evt.hit      = 1'b1;
                evt.long_rel = 1'b1;
            end
        end
        else if (!locked_reg)
        begin
            press_next = press_inc;
            if (kdrlp_pkg::cmp_t'(press_inc) > kdrlp_pkg::cmp_t'(cfg.debounce))
            begin
                press_next  = '0;
                locked_next = 1'b1;
                evt.hit     = 1'b1;
            end
        end
        else if (kdrlp_pkg::cmp_t'(press_reg) < kdrlp_pkg::cmp_t'(cfg.rpt_start))
        begin
            press_next = press_inc;
        end
        else
        begin
            press_next  = press_inc;
            repeat_next = repeat_inc;
            if (kdrlp_pkg::cmp_t'(repeat_inc) > kdrlp_pkg::cmp_t'(cfg.rpt_intv))
            begin
                repeat_next = '0;
                evt.hit     = 1'b1;
            end
            if (kdrlp_pkg::cmp_t'(press_inc) > kdrlp_pkg::cmp_t'(cfg.long_press))
            begin
                long_next = 1'b1;
            end
        end
    end

    // Advance the key state on each accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_reg  <= '0;
            repeat_reg <= '0;
            locked_reg <= 1'b0;
            long_reg   <= 1'b0;
        end
        else if (accept)
        begin
            press_reg  <= press_next;
            repeat_reg <= repeat_next;
            locked_reg <= locked_next;
            long_reg   <= long_next;
        end
    end

endmodule

// ===== sv/kdrlp_merge.sv =====
`timescale 1ns / 1ps

module kdrlp_merge
(
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         accept,
    input  kdrlp_pkg::lane_evt_t [kdrlp_pkg::NUM_KEYS-1:0] lane_evt,
    output logic                                         busy,
    output logic                                         out_valid,
    input  logic                                         out_stall,
    output kdrlp_pkg::key_num_t                          event_key,
    output logic                                         long_release
);

    kdrlp_pkg::key_num_t key_sel;
    logic                long_sel;
    logic                take;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                skid_valid_reg;
    logic                skid_valid_next;
    logic                load_out;
    logic                load_skid;
    logic                from_skid;
    kdrlp_pkg::key_num_t out_key_reg;
    logic                out_long_reg;
    kdrlp_pkg::key_num_t skid_key_reg;
    logic                skid_long_reg;

    // Pick the highest-numbered key with an event
    always_comb
    begin
        key_sel  = '0;
        long_sel = 1'b0;
        for (int i = 0; i < kdrlp_pkg::NUM_KEYS; i++)
        begin
            if (lane_evt[i].hit)
            begin
                key_sel  = kdrlp_pkg::key_num_t'(i + 1);
                long_sel = lane_evt[i].long_rel;
            end
        end
    end

    // Output word plus one skid word
    assign take = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out        = 1'b0;
        load_skid       = 1'b0;
        from_skid       = 1'b0;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                load_out        = 1'b1;
                from_skid       = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (!out_valid_reg || take)
            begin
                load_out       = 1'b1;
                out_valid_next = 1'b1;
            end
            else
            begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Hold the payload words
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_key_reg  <= from_skid ? skid_key_reg : key_sel;
            out_long_reg <= from_skid ? skid_long_reg : long_sel;
        end
        if (load_skid)
        begin
            skid_key_reg  <= key_sel;
            skid_long_reg <= long_sel;
        end
    end

    assign busy         = skid_valid_reg;
    assign out_valid    = out_valid_reg;
    assign event_key    = out_key_reg;
    assign long_release = out_long_reg;

endmodule

// ===== sv/key_debounce_repeat_long_press.sv =====
// Scans four keys, one tick per word on the input side, and gives one result word per
// tick: the highest-numbered key that pressed, auto-repeated or was released after a
// long hold, or 0. Each key has its own lane of counters; all lanes update in the
// cycle a tick is accepted, so a new tick can be taken every cycle in_stall is low.
// Results go to the output or skid register; this two-word buffer keeps taking ticks
// while one result waits; input stalls only when both are full. Write thresholds
// through the cfg port while no tick is in flight; the block does not enforce it.
`timescale 1ns / 1ps
`include "key_debounce_repeat_long_press_macros.svh"

module key_debounce_repeat_long_press
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [kdrlp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [kdrlp_pkg::CFG_WIDTH-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [kdrlp_pkg::LEVEL_BITS-1:0]    key_levels,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [kdrlp_pkg::KEY_WIDTH-1:0]     event_key,
    output logic                                long_release
);

    kdrlp_pkg::cfg_t                              cfg_reg;
    kdrlp_pkg::lane_evt_t [kdrlp_pkg::NUM_KEYS-1:0] lane_evt;
    logic                                         accept;
    logic                                         busy;

    assign accept   = in_valid && !in_stall;
    assign in_stall = busy;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce   <= kdrlp_pkg::DEBOUNCE_RST;
            cfg_reg.rpt_start  <= kdrlp_pkg::RPT_START_RST;
            cfg_reg.rpt_intv   <= kdrlp_pkg::RPT_INTV_RST;
            cfg_reg.long_press <= kdrlp_pkg::LONG_RST;
        end
        else if (cfg_we)
        begin
            case (kdrlp_pkg::cfg_reg_t'(cfg_index))
                kdrlp_pkg::REG_DEBOUNCE:  cfg_reg.debounce   <= cfg_data;
                kdrlp_pkg::REG_RPT_START: cfg_reg.rpt_start  <= cfg_data;
                kdrlp_pkg::REG_RPT_INTV:  cfg_reg.rpt_intv   <= cfg_data;
                kdrlp_pkg::REG_LONG:      cfg_reg.long_press <= cfg_data;
                default:                  cfg_reg            <= cfg_reg;
            endcase
        end
    end

    // One lane per key; keys past the level field read as released
    for (genvar g = 0; g < kdrlp_pkg::NUM_KEYS; g++)
    begin : g_lane
        logic released;
        if (g < kdrlp_pkg::LEVEL_BITS)
        begin : g_pin
            assign released = key_levels[g];
        end
        else
        begin : g_idle
            assign released = 1'b1;
        end

        kdrlp_lane u_lane
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .accept   (accept),
            .released (released),
            .cfg      (cfg_reg),
            .evt      (lane_evt[g])
        );
    end

    // Merge lane events and buffer the result word
    kdrlp_merge u_merge
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .lane_evt     (lane_evt),
        .busy         (busy),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_key    (event_key),
        .long_release (long_release)
    );

    // A full skid word means a result is also waiting at the output
    `KDRLP_ASSERT_NOW(a_stall_has_word, in_stall, out_valid)
    // A tick taken while the output is stalled lands in the skid word
    `KDRLP_ASSERT_NEXT(a_skid_fill, accept && out_valid && out_stall, in_stall && out_valid)
    // A long release always names a key
    `KDRLP_ASSERT_NOW(a_long_has_key, out_valid && long_release, event_key != '0)

endmodule
